[rtl/chtb_pkg.sv]
// ----------------------------------------------------------------------------
// chtb_pkg
// shared types and codes for the canonical huffman table builder
// ----------------------------------------------------------------------------
package chtb_pkg;

  localparam int SYM_W  = 16;
  localparam int CNT_W  = 14;
  localparam int CW_W   = 32;
  localparam int LEN_W  = 6;
  localparam int TOT_W  = 20;   // sum of up to 32 counts of 14 bits
  localparam int OP_W   = 3;
  localparam int KIND_W = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 3'd1;
  localparam logic [OP_W-1:0] OP_SYMBOL = 3'd2;
  localparam logic [OP_W-1:0] OP_FINISH = 3'd3;
  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd4;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_SYM    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LENGTH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

  localparam logic [CNT_W-1:0] NO_INDEX = '1;
  localparam logic [CW_W-1:0]  NO_CODE  = '1;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [CNT_W-1:0] count;
    logic [SYM_W-1:0] symbol;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SYM_W-1:0]  symbol_out;
    logic [CNT_W-1:0]  entry_index;
    logic [CW_W-1:0]   codeword;
    logic [CW_W-1:0]   max_codeword;
    logic [LEN_W-1:0]  code_length;
    logic              valid_res;
    logic              error;
    logic              last;
  } result_t;

  // one encode table entry
  typedef struct packed {
    logic             valid;
    logic [LEN_W-1:0] code_length;
    logic [CW_W-1:0]  codeword;
  } enc_entry_t;

  // encode table write request
  typedef struct packed {
    logic             en;
    logic [SYM_W-1:0] addr;
    enc_entry_t       data;
  } enc_wr_t;

endpackage

[rtl/chtb_count_mem.sv]
// ----------------------------------------------------------------------------
// chtb_count_mem
// per-length codeword count store, one write and one registered read port
// ----------------------------------------------------------------------------
module chtb_count_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [chtb_pkg::CNT_W-1:0] wr_data,
  input  logic [AW-1:0]             rd_addr,
  output logic [chtb_pkg::CNT_W-1:0] rd_data
);

  logic [chtb_pkg::CNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/chtb_enc_table.sv]
// ----------------------------------------------------------------------------
// chtb_enc_table
// per-symbol encode table with a clearing sweep after reset or clear
// ----------------------------------------------------------------------------
module chtb_enc_table #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  output logic                  busy,
  input  chtb_pkg::enc_wr_t     wr,
  input  logic [AW-1:0]         rd_addr,
  output chtb_pkg::enc_entry_t  rd_data
);

  chtb_pkg::enc_entry_t mem [DEPTH];
  logic [AW-1:0]        sweep;

  // sweep control
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      busy  <= 1'b1;
      sweep <= '0;
    end else if (busy) begin
      sweep <= sweep + 1'b1;
      if (sweep == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[sweep] <= '0;
    end else if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/canonical_huffman_table_builder_unit.sv]
// ----------------------------------------------------------------------------
// canonical_huffman_table_builder_unit
// builds canonical huffman codes from per-length counts, assigns codewords to
// symbols in table order, reports per-length ranges and answers lookups
// ----------------------------------------------------------------------------
// sequence: a count load writes the count memory; a symbol steps through lengths
//   (one count memory read per step); a lookup reads the encode table; a finish
//   gives one result per loaded length; each result then sits in the output reg
// throughput: one item at a time, next item taken once the result is queued
// reset and clear: the encode table sweep zeroes SYMBOL_SPACE entries (65536
//   by default) and no item is taken during it; a queued result still drains
// ----------------------------------------------------------------------------
module canonical_huffman_table_builder_unit #(
  parameter int MAX_CODE_LENGTH = 32,
  parameter int MAX_ENTRIES     = 16384,
  parameter int SYMBOL_SPACE    = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  chtb_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output chtb_pkg::result_t result
);

  // count memory address width, encode table address width, entry counter width
  localparam int CAW = (MAX_CODE_LENGTH > 1) ? $clog2(MAX_CODE_LENGTH) : 1;
  localparam int EAW = $clog2(SYMBOL_SPACE);
  localparam int EDW = $clog2(MAX_ENTRIES + 1);

  localparam logic [chtb_pkg::LEN_W-1:0] MAX_LEN = chtb_pkg::LEN_W'(MAX_CODE_LENGTH);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SKIP = 5'b00010,
    ST_FIN  = 5'b00100,
    ST_LOOK = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t state, state_next;

  // build state
  logic [chtb_pkg::LEN_W-1:0] lengths_loaded, lengths_loaded_next;
  logic [chtb_pkg::LEN_W-1:0] current_length, current_length_next;
  logic [chtb_pkg::CNT_W-1:0] index_in_length, index_in_length_next;
  logic [chtb_pkg::CW_W-1:0]  next_code, next_code_next;
  logic [EDW-1:0]             entries_done, entries_done_next;
  logic [chtb_pkg::TOT_W-1:0] total, total_next;

  // per-item working registers
  logic [chtb_pkg::LEN_W-1:0] old_len, old_len_next;
  logic [chtb_pkg::SYM_W-1:0] sym, sym_next;
  logic [chtb_pkg::LEN_W-1:0] fin_len, fin_len_next;
  logic [chtb_pkg::LEN_W-1:0] fin_prev, fin_prev_next;
  logic [chtb_pkg::CW_W-1:0]  fin_code, fin_code_next;
  logic [chtb_pkg::CNT_W-1:0] fin_entry, fin_entry_next;
  logic                       fin_err, fin_err_next;
  logic                       emit_more, emit_more_next;
  chtb_pkg::result_t          res, res_next;

  // memory ports
  logic                       count_wr_en;
  logic [CAW-1:0]             count_rd_addr;
  logic [chtb_pkg::CNT_W-1:0] count_q;
  chtb_pkg::enc_wr_t          enc_wr;
  logic [EAW-1:0]             enc_rd_addr;
  chtb_pkg::enc_entry_t       enc_q;
  logic                       enc_busy;
  logic                       clear_start;

  logic                       item_accept;
  logic                       out_load;
  logic [chtb_pkg::TOT_W-1:0] total_eff;
  logic                       sym_err;
  logic                       sym_range_err;
  logic                       look_miss;
  logic [chtb_pkg::LEN_W-1:0] cur_m1;
  logic [chtb_pkg::LEN_W-1:0] fin_m1;
  logic [chtb_pkg::CW_W-1:0]  skip_cw;
  logic [chtb_pkg::CW_W-1:0]  fin_min;
  logic [chtb_pkg::CW_W-1:0]  fin_max;

  chtb_count_mem #(
    .DEPTH (MAX_CODE_LENGTH),
    .AW    (CAW)
  ) u_count_mem (
    .clk     (clk),
    .wr_en   (count_wr_en),
    .wr_addr (lengths_loaded[CAW-1:0]),
    .wr_data (item.count),
    .rd_addr (count_rd_addr),
    .rd_data (count_q)
  );

  chtb_enc_table #(
    .DEPTH (SYMBOL_SPACE),
    .AW    (EAW)
  ) u_enc_table (
    .clk     (clk),
    .rst     (rst),
    .clear   (clear_start),
    .busy    (enc_busy),
    .wr      (enc_wr),
    .rd_addr (enc_rd_addr),
    .rd_data (enc_q)
  );

  // items only enter an idle sequencer, never during the table sweep
  assign item_stall  = (state != ST_IDLE) || enc_busy;
  assign item_accept = item_valid && !item_stall;
  assign out_load    = (state == ST_EMIT) && (!result_valid || !result_stall);

  // with no counts loaded the table holds a single length-0 entry
  assign total_eff = (lengths_loaded == '0) ? chtb_pkg::TOT_W'(1) : total;

  assign sym_range_err = {1'b0, item.symbol} >= (chtb_pkg::SYM_W + 1)'(SYMBOL_SPACE);
  assign sym_err = (chtb_pkg::TOT_W'(entries_done) >= total_eff)
                || (entries_done >= EDW'(MAX_ENTRIES))
                || sym_range_err;

  assign look_miss = ({1'b0, sym} >= (chtb_pkg::SYM_W + 1)'(SYMBOL_SPACE)) || !enc_q.valid;

  assign cur_m1 = current_length - 1'b1;
  assign fin_m1 = fin_len - 1'b1;

  // canonical step: previous code plus one, shifted by the growth in length
  assign skip_cw = next_code << 5'(current_length - old_len);
  assign fin_min = fin_code << 5'(fin_len - fin_prev);
  assign fin_max = fin_min + chtb_pkg::CW_W'(count_q - 1'b1);

  always_comb begin
    state_next           = state;
    lengths_loaded_next  = lengths_loaded;
    current_length_next  = current_length;
    index_in_length_next = index_in_length;
    next_code_next       = next_code;
    entries_done_next    = entries_done;
    total_next           = total;
    old_len_next         = old_len;
    sym_next             = sym;
    fin_len_next         = fin_len;
    fin_prev_next        = fin_prev;
    fin_code_next        = fin_code;
    fin_entry_next       = fin_entry;
    fin_err_next         = fin_err;
    emit_more_next       = emit_more;
    res_next             = res;
    count_wr_en          = 1'b0;
    count_rd_addr        = cur_m1[CAW-1:0];
    enc_wr               = '0;
    enc_rd_addr          = item.symbol[EAW-1:0];
    clear_start          = 1'b0;

    case (state)
      ST_IDLE: begin
        if (item_accept) begin
          sym_next       = item.symbol;
          old_len_next   = current_length;
          emit_more_next = 1'b0;
          case (item.operation)
            chtb_pkg::OP_CLEAR: begin
              clear_start          = 1'b1;
              lengths_loaded_next  = '0;
              current_length_next  = chtb_pkg::LEN_W'(1);
              index_in_length_next = '0;
              next_code_next       = '0;
              entries_done_next    = '0;
              total_next           = '0;
            end
            chtb_pkg::OP_LOAD: begin
              if (entries_done != '0 || lengths_loaded >= MAX_LEN) begin
                // refused load
                res_next       = '0;
                res_next.error = 1'b1;
                res_next.last  = 1'b1;
                state_next     = ST_EMIT;
              end else begin
                count_wr_en         = 1'b1;
                total_next          = total + chtb_pkg::TOT_W'(item.count);
                lengths_loaded_next = lengths_loaded + 1'b1;
              end
            end
            chtb_pkg::OP_SYMBOL: begin
              res_next             = '0;
              res_next.kind        = chtb_pkg::KIND_SYM;
              res_next.symbol_out  = item.symbol;
              res_next.entry_index = chtb_pkg::CNT_W'(entries_done);
              res_next.last        = 1'b1;
              if (sym_err) begin
                res_next.error = 1'b1;
                state_next     = ST_EMIT;
              end else if (lengths_loaded == '0) begin
                // single length-0 symbol
                enc_wr.en          = 1'b1;
                enc_wr.addr        = item.symbol;
                enc_wr.data.valid  = 1'b1;
                res_next.valid_res = 1'b1;
                next_code_next     = chtb_pkg::CW_W'(1);
                entries_done_next  = entries_done + 1'b1;
                state_next         = ST_EMIT;
              end else begin
                state_next = ST_SKIP;
              end
            end
            chtb_pkg::OP_FINISH: begin
              if (lengths_loaded != '0) begin
                fin_len_next   = chtb_pkg::LEN_W'(1);
                fin_prev_next  = chtb_pkg::LEN_W'(1);
                fin_code_next  = '0;
                fin_entry_next = '0;
                fin_err_next   = chtb_pkg::TOT_W'(entries_done) != total_eff;
                count_rd_addr  = '0;
                state_next     = ST_FIN;
              end
            end
            chtb_pkg::OP_LOOKUP: begin
              state_next = ST_LOOK;
            end
            default: ;
          endcase
        end
      end

      ST_SKIP: begin
        if (index_in_length >= count_q) begin
          // this length is used up, move on to the next one
          current_length_next  = current_length + 1'b1;
          index_in_length_next = '0;
          count_rd_addr        = current_length[CAW-1:0];
          if (current_length >= lengths_loaded) begin
            res_next.error = 1'b1;
            state_next     = ST_EMIT;
          end
        end else begin
          enc_wr.en               = 1'b1;
          enc_wr.addr             = sym;
          enc_wr.data.valid       = 1'b1;
          enc_wr.data.code_length = current_length;
          enc_wr.data.codeword    = skip_cw;
          res_next.codeword       = skip_cw;
          res_next.code_length    = current_length;
          res_next.valid_res      = 1'b1;
          next_code_next          = skip_cw + 1'b1;
          index_in_length_next    = index_in_length + 1'b1;
          entries_done_next       = entries_done + 1'b1;
          state_next              = ST_EMIT;
        end
      end

      ST_FIN: begin
        res_next             = '0;
        res_next.kind        = chtb_pkg::KIND_LENGTH;
        res_next.code_length = fin_len;
        res_next.error       = fin_err;
        res_next.last        = fin_len == lengths_loaded;
        if (count_q != '0) begin
          res_next.entry_index  = fin_entry;
          res_next.codeword     = fin_min;
          res_next.max_codeword = fin_max;
          res_next.valid_res    = 1'b1;
          fin_entry_next        = fin_entry + count_q;
          fin_code_next         = fin_min + chtb_pkg::CW_W'(count_q);
          fin_prev_next         = fin_len;
        end else begin
          // empty length
          res_next.entry_index  = chtb_pkg::NO_INDEX;
          res_next.codeword     = chtb_pkg::NO_CODE;
          res_next.max_codeword = chtb_pkg::NO_CODE;
        end
        emit_more_next = fin_len != lengths_loaded;
        fin_len_next   = fin_len + 1'b1;
        state_next     = ST_EMIT;
      end

      ST_LOOK: begin
        res_next            = '0;
        res_next.kind       = chtb_pkg::KIND_LOOKUP;
        res_next.symbol_out = sym;
        res_next.last       = 1'b1;
        if (!look_miss) begin
          res_next.codeword    = enc_q.codeword;
          res_next.code_length = enc_q.code_length;
          res_next.valid_res   = 1'b1;
        end
        state_next = ST_EMIT;
      end

      ST_EMIT: begin
        // prefetch the count of the next length of a finish run
        count_rd_addr = fin_m1[CAW-1:0];
        if (out_load) begin
          state_next = emit_more ? ST_FIN : ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      lengths_loaded  <= '0;
      current_length  <= chtb_pkg::LEN_W'(1);
      index_in_length <= '0;
      next_code       <= '0;
      entries_done    <= '0;
      total           <= '0;
      emit_more       <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      state           <= state_next;
      lengths_loaded  <= lengths_loaded_next;
      current_length  <= current_length_next;
      index_in_length <= index_in_length_next;
      next_code       <= next_code_next;
      entries_done    <= entries_done_next;
      total           <= total_next;
      emit_more       <= emit_more_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    old_len   <= old_len_next;
    sym       <= sym_next;
    fin_len   <= fin_len_next;
    fin_prev  <= fin_prev_next;
    fin_code  <= fin_code_next;
    fin_entry <= fin_entry_next;
    fin_err   <= fin_err_next;
    res       <= res_next;
    if (out_load) begin
      result <= res;
    end
  end

  // symbols assigned never pass the total of the loaded counts
  a_entries_bound: assert property (@(posedge clk) disable iff (rst)
    (lengths_loaded != '0) |-> (chtb_pkg::TOT_W'(entries_done) <= total))
    else $error("entries_done beyond total count");

  // the length walk only reads lengths that were loaded
  a_skip_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SKIP) |-> (current_length != '0 && current_length <= lengths_loaded))
    else $error("length walk outside loaded lengths");

  // the table sweep never overlaps a job in flight
  a_sweep_idle: assert property (@(posedge clk) disable iff (rst)
    enc_busy |-> (state == ST_IDLE))
    else $error("encode table sweep during a job");

  // counts are loaded only before any symbol is assigned
  a_load_order: assert property (@(posedge clk) disable iff (rst)
    count_wr_en |-> (entries_done == '0 && lengths_loaded < MAX_LEN))
    else $error("count load after symbols started");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the canonical huffman table builder: a queue of
// beats feeds a bursty driver, a clocked monitor predicts every result from
// its own copy of the count, code and encode tables and checks each result
// beat field by field while the result side stalls on its own pattern
// ----------------------------------------------------------------------------
module tb;
  import chtb_pkg::*;

  localparam int MAX_LENGTHS = 32;
  localparam int ENTRY_CAP   = 16384;
  localparam int SYM_SPACE   = 65536;
  localparam int MAX_COUNT   = 16383;
  localparam int RANDOM_BEATS = 460;

  // operation codes the block ignores
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  // one queued beat, or a hold that waits until no result is outstanding
  typedef struct packed {
    logic  hold;
    item_t beat;
  } stim_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  stim_t   pending_beats[$];
  result_t code_results_q[$];
  int      fail_count = 0;
  int      queued_beats = 0;

  // bench copy of the builder state
  logic [CNT_W-1:0] cnt_by_len [MAX_LENGTHS];
  logic [LEN_W-1:0] n_lengths;
  logic [LEN_W-1:0] cur_len;
  logic [CNT_W-1:0] pos_in_len;
  logic [CW_W-1:0]  next_cw;
  logic [14:0]      n_assigned;
  enc_entry_t       code_book [SYM_SPACE];

  canonical_huffman_table_builder_unit #(
    .MAX_CODE_LENGTH (MAX_LENGTHS),
    .MAX_ENTRIES     (ENTRY_CAP),
    .SYMBOL_SPACE    (SYM_SPACE)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // table predictor
  // ---------------------------------------------------------------------------

  // back to the post-reset state: no counts, every encode entry invalid
  task automatic clear_tables();
    int i;
    for (i = 0; i < MAX_LENGTHS; i++) cnt_by_len[i] = '0;
    for (i = 0; i < SYM_SPACE; i++) code_book[i] = '0;
    n_lengths  = '0;
    cur_len    = 1;
    pos_in_len = '0;
    next_cw    = '0;
    n_assigned = '0;
  endtask

  // entries the loaded counts call for; an empty table holds one entry
  function automatic int unsigned table_size();
    int unsigned sum;
    int i;
    sum = 0;
    if (n_lengths == 0) return 1;
    for (i = 0; i < n_lengths; i++) sum += cnt_by_len[i];
    return sum;
  endfunction

  // append one predicted result beat
  task automatic expect_result(result_t r);
    code_results_q.insert(code_results_q.size(), r);
  endtask

  // apply one accepted beat to the bench tables, queue the results it causes
  task automatic apply_table_op(item_t it);
    result_t          r;
    int unsigned      total, entry;
    int               l;
    logic [31:0]      c, cw, mn, mx, run_code;
    logic [LEN_W-1:0] len, old_len, prev_len;
    logic             err_all;
    r = '0;
    cw = '0;
    len = '0;
    case (it.operation)
      OP_CLEAR: begin
        clear_tables();
      end
      OP_LOAD: begin
        // a load once symbols started, or past the last length, is refused
        if (n_assigned > 0 || n_lengths >= MAX_LENGTHS) begin
          r.kind  = KIND_SYM;
          r.error = 1'b1;
          r.last  = 1'b1;
          expect_result(r);
        end else begin
          cnt_by_len[n_lengths] = it.count;
          n_lengths++;
        end
      end
      OP_SYMBOL: begin
        total = table_size();
        r.kind        = KIND_SYM;
        r.symbol_out  = it.symbol;
        r.entry_index = n_assigned[CNT_W-1:0];
        r.last        = 1'b1;
        if (n_assigned >= total || n_assigned >= ENTRY_CAP) begin
          r.error = 1'b1;
        end else if (n_lengths != 0) begin
          // skip exhausted and empty lengths; the codeword shifts by the growth
          old_len = cur_len;
          while (cur_len <= n_lengths && pos_in_len >= cnt_by_len[cur_len - 1]) begin
            cur_len++;
            pos_in_len = '0;
          end
          if (cur_len > n_lengths) begin
            r.error = 1'b1;
          end else begin
            len = cur_len;
            cw  = next_cw;
            if (len > old_len) cw = cw << (len - old_len);
            pos_in_len++;
          end
        end
        if (!r.error) begin
          next_cw = cw + 1;
          code_book[it.symbol] = '{valid: 1'b1, code_length: len, codeword: cw};
          r.codeword    = cw;
          r.code_length = len;
          r.valid_res   = 1'b1;
          n_assigned++;
        end
        expect_result(r);
      end
      OP_FINISH: begin
        // per-length ranges come from the counts alone
        err_all  = (n_assigned != table_size());
        run_code = '0;
        prev_len = 1;
        entry    = 0;
        for (l = 1; l <= n_lengths; l++) begin
          c = cnt_by_len[l - 1];
          r = '0;
          r.kind        = KIND_LENGTH;
          r.code_length = LEN_W'(l);
          r.error       = err_all;
          r.last        = (l == n_lengths);
          if (c > 0) begin
            mn = run_code << (LEN_W'(l) - prev_len);
            mx = mn + c - 1;
            r.entry_index  = CNT_W'(entry);
            r.codeword     = mn;
            r.max_codeword = mx;
            r.valid_res    = 1'b1;
            entry    += c;
            run_code  = mx + 1;
            prev_len  = LEN_W'(l);
          end else begin
            r.entry_index  = NO_INDEX;
            r.codeword     = NO_CODE;
            r.max_codeword = NO_CODE;
          end
          expect_result(r);
        end
      end
      OP_LOOKUP: begin
        r.kind       = KIND_LOOKUP;
        r.symbol_out = it.symbol;
        r.last       = 1'b1;
        if (code_book[it.symbol].valid) begin
          r.codeword    = code_book[it.symbol].codeword;
          r.code_length = code_book[it.symbol].code_length;
          r.valid_res   = 1'b1;
        end
        expect_result(r);
      end
      default: begin
        // spare codes: ignored
      end
    endcase
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_item(int unsigned op, int unsigned cnt, int unsigned sym);
    stim_t b;
    b.hold           = 1'b0;
    b.beat.operation = OP_W'(op);
    b.beat.count     = CNT_W'(cnt);
    b.beat.symbol    = SYM_W'(sym);
    pending_beats.insert(pending_beats.size(), b);
    queued_beats++;
  endtask

  // sender holds off until every pending result has drained
  task automatic add_pause();
    stim_t b;
    b = '0;
    b.hold = 1'b1;
    pending_beats.insert(pending_beats.size(), b);
  endtask

  // one table build: counts, symbols in table order with some noise, finish,
  // then lookups mostly of assigned symbols
  task automatic add_build(int nlen, int max_cnt, bit do_clear);
    int unsigned      total, nsym, c, nlook;
    int               i;
    logic [SYM_W-1:0] s;
    logic [SYM_W-1:0] used[$];
    total = 0;
    if (do_clear) begin
      if ($urandom_range(0, 2) == 0) add_pause();
      add_item(OP_CLEAR, $urandom, $urandom);
    end
    for (i = 0; i < nlen; i++) begin
      if ($urandom_range(0, 24) == 0) c = $urandom_range(0, MAX_COUNT);
      else if ($urandom_range(0, 3) == 0) c = 0;
      else c = $urandom_range(1, max_cnt);
      add_item(OP_LOAD, c, $urandom);
      if (i < MAX_LENGTHS) total += c;
    end
    case ($urandom_range(0, 5))
      0:       nsym = total + 1;
      1:       nsym = (total > 0) ? total - 1 : 0;
      default: nsym = total;
    endcase
    // without a clear the loads bounce and the table is whatever came before
    if (!do_clear) nsym = $urandom_range(0, 6);
    if (nsym > 80) nsym = $urandom_range(1, 80);
    for (i = 0; i < nsym; i++) begin
      if (used.size() > 0 && $urandom_range(0, 11) == 0)
        s = used[$urandom_range(0, used.size() - 1)];
      else
        s = SYM_W'($urandom);
      add_item(OP_SYMBOL, $urandom, s);
      used.insert(used.size(), s);
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0:       add_item(OP_LOAD, $urandom, $urandom);
          1:       add_item($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST), $urandom, $urandom);
          2:       add_item(OP_LOOKUP, $urandom, $urandom);
          default: add_item(OP_FINISH, $urandom, $urandom);
        endcase
      end
    end
    add_item(OP_FINISH, $urandom, $urandom);
    nlook = $urandom_range(5, 25);
    for (i = 0; i < nlook; i++) begin
      if (used.size() > 0 && $urandom_range(0, 2) != 0)
        s = used[$urandom_range(0, used.size() - 1)];
      else
        s = SYM_W'($urandom);
      add_item(OP_LOOKUP, $urandom, s);
    end
    if ($urandom_range(0, 4) == 0) add_item(OP_FINISH, $urandom, $urandom);
  endtask

  // ---------------------------------------------------------------------------
  // item driver: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  int    burst_left = 8;
  int    gap_left   = 0;

  always @(posedge clk) begin : drive_items
    stim_t nxt;
    bit    take;
    take = 1'b0;
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || !item_stall) begin
      // the current beat is gone (or there was none): pick what comes next
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_beats.size() > 0) begin
        if (pending_beats[0].hold) begin
          // wait for valid to drop so the last beat is predicted
          if (!item_valid && code_results_q.size() == 0) void'(pending_beats.pop_front());
        end else begin
          take = 1'b1;
        end
      end
      if (take) begin
        nxt = pending_beats.pop_front();
        item       <= nxt.beat;
        item_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          if ($urandom_range(0, 5) == 0) begin
            // long stretch with no idling
            burst_left = $urandom_range(50, 200);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result stall: a rotating 16-bit pattern, reloaded when its age runs out,
  // sometimes all clear so results stream back to back
  // ---------------------------------------------------------------------------
  logic [15:0] stall_pat = '0;
  int          pat_age   = 0;

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        pat_age = 64;
        case ($urandom_range(0, 3))
          0:       stall_pat = '0;
          1:       stall_pat = 16'($urandom);
          default: stall_pat = 16'($urandom & $urandom);
        endcase
      end
      pat_age--;
      result_stall <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on each accepted item beat, check each result beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_ports
    result_t want;
    if (!rst) begin
      if (item_valid && !item_stall) apply_table_op(item);
      if (result_valid && !result_stall) begin
        if (code_results_q.size() == 0) begin
          fail_count++;
          $error("result beat with nothing pending: kind %0d symbol 0x%0h",
                 result.kind, result.symbol_out);
        end else begin
          want = code_results_q.pop_front();
          check_field("kind",         32'(want.kind),         32'(result.kind));
          check_field("symbol_out",   32'(want.symbol_out),   32'(result.symbol_out));
          check_field("entry_index",  32'(want.entry_index),  32'(result.entry_index));
          check_field("codeword",     want.codeword,          result.codeword);
          check_field("max_codeword", want.max_codeword,      result.max_codeword);
          check_field("code_length",  32'(want.code_length),  32'(result.code_length));
          check_field("valid_res",    32'(want.valid_res),    32'(result.valid_res));
          check_field("error",        32'(want.error),        32'(result.error));
          check_field("last",         32'(want.last),         32'(result.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // reset
  // ---------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : run_stimulus
    int start;
    clear_tables();

    // empty table: finish says nothing, the single entry gets length 0
    add_item(OP_FINISH, 0, 0);
    add_item(OP_SYMBOL, 0, 16'hFFFF);
    add_item(OP_SYMBOL, 0, 16'h0000);          // past the single entry
    add_item(OP_LOOKUP, 0, 16'hFFFF);
    add_item(OP_LOOKUP, MAX_COUNT, 16'h0000);  // never assigned
    add_item(OP_LOAD, 3, 16'h0001);            // load after symbols started
    add_item(OP_SPARE_FIRST, MAX_COUNT, 16'hFFFF);
    add_item(OP_SPARE_FIRST + 1, 0, 0);
    add_item(OP_SPARE_LAST, MAX_COUNT, 16'h8000);
    add_pause();

    // empty lengths in between: codes 00, then 0100 and 0101
    add_item(OP_CLEAR, MAX_COUNT, 16'hFFFF);
    add_item(OP_LOAD, 0, 0);
    add_item(OP_LOAD, 1, 0);
    add_item(OP_LOAD, 0, 0);
    add_item(OP_LOAD, 2, 0);
    add_item(OP_SYMBOL, 0, 16'h0000);
    add_item(OP_SYMBOL, 0, 16'hAAAA);
    add_item(OP_SYMBOL, 0, 16'h5555);
    add_item(OP_SYMBOL, 0, 16'h1111);          // past the total count
    add_item(OP_FINISH, 0, 0);
    add_item(OP_LOOKUP, 0, 16'h5555);
    add_item(OP_LOOKUP, 0, 16'h1111);

    // widest count, a repeated symbol, finish on an incomplete table
    add_item(OP_CLEAR, 0, 0);
    add_item(OP_LOAD, MAX_COUNT, 0);
    add_item(OP_SYMBOL, 0, 16'h1234);
    add_item(OP_SYMBOL, 0, 16'h1234);
    add_item(OP_FINISH, 0, 0);
    add_item(OP_LOOKUP, 0, 16'h1234);

    // random builds; the first one runs past the last length
    start = queued_beats;
    add_build(MAX_LENGTHS + 1, 2, 1'b1);
    while (queued_beats - start < RANDOM_BEATS) begin
      case ($urandom_range(0, 9))
        0:       add_build($urandom_range(28, MAX_LENGTHS + 1), 2, 1'b1);
        1:       add_build($urandom_range(1, 4), 10, 1'b0);
        default: add_build($urandom_range(1, 14), 10, 1'b1);
      endcase
    end

    // wait for every beat to go in and every result to come back
    while (pending_beats.size() != 0 || item_valid) @(posedge clk);
    while (code_results_q.size() != 0) @(posedge clk);
    // a 32-length finish passes finish and emit per length, then the output reg
    repeat (300) @(posedge clk);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // timeout: worst case is about 80 encode table sweeps of 65536 entries each,
  // plus every result held by the longest stall pattern
  initial begin
    #250_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[filelist.f]
rtl/chtb_pkg.sv
rtl/chtb_count_mem.sv
rtl/chtb_enc_table.sv
rtl/canonical_huffman_table_builder_unit.sv
tb/sv/tb.sv
